>>> src/assert_macros.svh
// Assertion macros shared by the SipHash short-message core.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> src/siphsm_pkg.sv
// Types, constants and round functions for the SipHash short-message core.
// Depends on nothing.
package siphsm_pkg;

  localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
  localparam logic [63:0] SIP_FINAL_XOR = 64'h00000000000000ff;
  localparam int LEN_SHIFT = 56;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int CFG_IDX_W = 1;
  localparam logic [3:0] FULL_COUNT = 4'd8;

  typedef logic [63:0] word_t;
  typedef logic [3:0][63:0] chain_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW  = 1'b0,
    CFG_KEY_HIGH = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [63:0] message_word;
    logic [3:0]  byte_count;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest;
    logic [31:0] digest_folded;
  } out_item_t;

  typedef struct packed {
    logic  first_blk;
    logic  last_blk;
    word_t m;
  } blk_t;

  function automatic word_t rotl(word_t x, int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic chain_t sip_round(chain_t v);
    word_t v0, v1, v2, v3;
    v0 = v[0];
    v1 = v[1];
    v2 = v[2];
    v3 = v[3];
    v0 = v0 + v1;
    v1 = rotl(v1, 13) ^ v0;
    v0 = rotl(v0, 32);
    v2 = v2 + v3;
    v3 = rotl(v3, 16) ^ v2;
    v0 = v0 + v3;
    v3 = rotl(v3, 21) ^ v0;
    v2 = v2 + v1;
    v1 = rotl(v1, 17) ^ v2;
    v2 = rotl(v2, 32);
    return {v3, v2, v1, v0};
  endfunction

  function automatic chain_t init_chain(word_t k0, word_t k1);
    return {k1 ^ SIP_C3, k0 ^ SIP_C2, k1 ^ SIP_C1, k0 ^ SIP_C0};
  endfunction

endpackage

>>> src/siphsm_front.sv
// Front end: accepts message words, tracks the length byte and splits each
// word into absorb blocks for the queue. Depends on siphsm_pkg.
`include "assert_macros.svh"
module siphsm_front import siphsm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output blk_t     q_blk
);

  logic       open_r, open_nxt;
  logic [7:0] len_r, len_nxt;
  logic       pend_r, pend_nxt;
  logic [7:0] pend_len_r, pend_len_nxt;

  logic       in_acc;
  logic       eff8;
  logic [3:0] count_eff;
  logic [7:0] len_sum;
  word_t      tail;

  always_comb begin
    eff8      = !in_data.last_word || in_data.byte_count[3];
    count_eff = eff8 ? FULL_COUNT : in_data.byte_count;
    len_sum   = (open_r ? len_r : 8'd0) + {4'd0, count_eff};
    for (int b = 0; b < 8; b++) begin
      tail[8*b +: 8] = (4'(b) < count_eff) ? in_data.message_word[8*b +: 8] : 8'd0;
    end
    tail[63:LEN_SHIFT] = len_sum;
  end

  assign in_stall = pend_r || q_full;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    open_nxt     = open_r;
    len_nxt      = len_r;
    pend_nxt     = pend_r;
    pend_len_nxt = pend_len_r;
    q_push       = 1'b0;
    q_blk        = '{first_blk: 1'b0, last_blk: 1'b1,
                     m: {pend_len_r, {LEN_SHIFT{1'b0}}}};
    if (pend_r) begin
      if (!q_full) begin
        q_push   = 1'b1;
        pend_nxt = 1'b0;
      end
    end else if (in_acc) begin
      q_push   = 1'b1;
      open_nxt = !in_data.last_word;
      len_nxt  = len_sum;
      q_blk.first_blk = !open_r;
      if (!in_data.last_word || eff8) begin
        q_blk.last_blk = 1'b0;
        q_blk.m        = in_data.message_word;
        if (in_data.last_word) begin
          pend_nxt     = 1'b1;
          pend_len_nxt = len_sum;
        end
      end else begin
        q_blk.last_blk = 1'b1;
        q_blk.m        = tail;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      len_r  <= 8'd0;
      pend_r <= 1'b0;
    end else begin
      open_r <= open_nxt;
      len_r  <= len_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_len_r <= pend_len_nxt;
  end

  `ASSERT_CLK(a_split_full_last, in_acc && in_data.last_word && eff8 |=> pend_r && in_stall, "full last word did not raise length block")
  `ASSERT_CLK(a_pend_pushes_last, pend_r && q_push |-> q_blk.last_blk && !q_blk.first_blk, "length block pushed with wrong flags")

endmodule

>>> src/siphsm_queue.sv
// Short block queue between front end and compression unit.
// Depends on siphsm_pkg.
`include "assert_macros.svh"
module siphsm_queue import siphsm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  blk_t push_blk,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output blk_t pop_blk
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  blk_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_blk   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_blk;
    end
  end

  `ASSERT_CLK(a_no_overflow, push |-> !full, "push into full queue")
  `ASSERT_CLK(a_no_underflow, pop |-> pop_valid, "pop from empty queue")

endmodule

>>> src/siphsm_compress.sv
// Compression unit: two unrolled rounds absorb one queued block per cycle;
// a last block waits on fin_ready; its chain goes on. Depends on siphsm_pkg.
module siphsm_compress import siphsm_pkg::*; (
  input  logic   clk,
  input  word_t  key_low,
  input  word_t  key_high,
  input  logic   q_valid,
  input  blk_t   q_blk,
  output logic   q_pop,
  input  logic   fin_ready,
  output logic   fin_valid,
  output chain_t fin_chain
);

  chain_t chain_r, chain_nxt;
  chain_t base;
  chain_t absorbed;

  always_comb begin
    base        = q_blk.first_blk ? init_chain(key_low, key_high) : chain_r;
    base[3]     = base[3] ^ q_blk.m;
    absorbed    = sip_round(sip_round(base));
    absorbed[0] = absorbed[0] ^ q_blk.m;
    fin_chain    = absorbed;
    fin_chain[2] = absorbed[2] ^ SIP_FINAL_XOR;
  end

  assign q_pop     = q_valid && (!q_blk.last_blk || fin_ready);
  assign fin_valid = q_valid && q_blk.last_blk;

  always_comb begin
    chain_nxt = chain_r;
    if (q_pop && !q_blk.last_blk) begin
      chain_nxt = absorbed;
    end
  end

  always_ff @(posedge clk) begin
    chain_r <= chain_nxt;
  end

endmodule

>>> src/siphsm_final.sv
// Finalisation pipeline: four rounds over two stages, then the digest and
// its fold in the output register. Depends on siphsm_pkg.
`include "assert_macros.svh"
module siphsm_final import siphsm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fin_valid,
  input  chain_t    fin_chain,
  output logic      fin_ready,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      fa_v_r, fb_v_r, out_v_r;
  chain_t    fa_r, fb_r;
  out_item_t out_r;
  logic      a_ready, b_ready, o_ready;
  chain_t    fb_nxt, tail_rounds;
  word_t     dig;

  assign o_ready   = !out_v_r || !out_stall;
  assign b_ready   = !fb_v_r || o_ready;
  assign a_ready   = !fa_v_r || b_ready;
  assign fin_ready = a_ready;

  always_comb begin
    fb_nxt      = sip_round(sip_round(fa_r));
    tail_rounds = sip_round(sip_round(fb_r));
    dig         = tail_rounds[0] ^ tail_rounds[1] ^ tail_rounds[2] ^ tail_rounds[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_v_r  <= 1'b0;
      fb_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (a_ready) begin
        fa_v_r <= fin_valid;
      end
      if (b_ready) begin
        fb_v_r <= fa_v_r;
      end
      if (o_ready) begin
        out_v_r <= fb_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && fin_valid) begin
      fa_r <= fin_chain;
    end
    if (b_ready && fa_v_r) begin
      fb_r <= fb_nxt;
    end
    if (o_ready && fb_v_r) begin
      out_r.digest        <= dig;
      out_r.digest_folded <= dig[63:32] ^ dig[31:0];
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  `ASSERT_CLK(a_stage_a_holds, fa_v_r && !b_ready |=> fa_v_r && $stable(fa_r), "stage A lost a held message")
  `ASSERT_CLK(a_stage_b_holds, fb_v_r && !o_ready |=> fb_v_r && $stable(fb_r), "stage B lost a held message")

endmodule

>>> src/siphash_2_4_short_message_core.sv
// Keyed SipHash-2-4 over short messages given as little-endian 64-bit words.
// One word is taken per cycle while the block queue has room and no length
// block is pending; a full eight-byte last word also yields a separate
// length block, pushed after it while input is stalled. Compression runs
// two unrolled rounds per block; each message's digest and 32-bit fold
// then pass a two-stage finalisation pipeline and an output register.
module siphash_2_4_short_message_core import siphsm_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  word_t  key_low_r, key_high_r;
  logic   q_push, q_full, q_pop, q_valid;
  blk_t   q_push_blk, q_pop_blk;
  logic   fin_valid, fin_ready;
  chain_t fin_chain;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KEY_LOW:  key_low_r  <= cfg_data;
        CFG_KEY_HIGH: key_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  siphsm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_blk    (q_push_blk)
  );

  siphsm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_blk  (q_push_blk),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_blk   (q_pop_blk)
  );

  siphsm_compress u_compress (
    .clk       (clk),
    .key_low   (key_low_r),
    .key_high  (key_high_r),
    .q_valid   (q_valid),
    .q_blk     (q_pop_blk),
    .q_pop     (q_pop),
    .fin_ready (fin_ready),
    .fin_valid (fin_valid),
    .fin_chain (fin_chain)
  );

  siphsm_final u_final (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin_valid (fin_valid),
    .fin_chain (fin_chain),
    .fin_ready (fin_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> tb/siphash_2_4_short_message_core_tb.sv
// Self-checking bench for the SipHash-2-4 short-message core: directed and random
// messages under several keys, with random input gaps and output stalls.
// Depends on siphsm_pkg and siphash_2_4_short_message_core.
module siphash_2_4_short_message_core_tb;
  import siphsm_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PHASE_WORDS   = 110;
  localparam logic [63:0] ONES          = {64{1'b1}};

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;

  in_item_t    words_pending[$];
  out_item_t   digests_due[$];
  logic [63:0] hash_key_lo, hash_key_hi;
  logic [63:0] chain_v[4];
  logic [7:0]  msg_len;
  bit          msg_open;

  bit          in_took, out_took;
  bit          in_calm, out_calm;
  int unsigned in_gap, stall_left;
  int unsigned cycle_cnt;
  int unsigned fail_cnt;

  siphash_2_4_short_message_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] rol64(logic [63:0] x, int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic void sip_mix(int unsigned n);
    int unsigned r;
    for (r = 0; r < n; r++) begin
      chain_v[0] = chain_v[0] + chain_v[1];
      chain_v[1] = rol64(chain_v[1], 13) ^ chain_v[0];
      chain_v[0] = rol64(chain_v[0], 32);
      chain_v[2] = chain_v[2] + chain_v[3];
      chain_v[3] = rol64(chain_v[3], 16) ^ chain_v[2];
      chain_v[0] = chain_v[0] + chain_v[3];
      chain_v[3] = rol64(chain_v[3], 21) ^ chain_v[0];
      chain_v[2] = chain_v[2] + chain_v[1];
      chain_v[1] = rol64(chain_v[1], 17) ^ chain_v[2];
      chain_v[2] = rol64(chain_v[2], 32);
    end
  endfunction

  function automatic void absorb_block(logic [63:0] m);
    chain_v[3] = chain_v[3] ^ m;
    sip_mix(2);
    chain_v[0] = chain_v[0] ^ m;
  endfunction

  function automatic void hash_word(in_item_t beat);
    logic [3:0]  nbytes;
    logic [63:0] tail;
    logic [63:0] dg;
    out_item_t   res;
    if (!msg_open) begin
      chain_v[0] = hash_key_lo ^ SIP_C0;
      chain_v[1] = hash_key_hi ^ SIP_C1;
      chain_v[2] = hash_key_lo ^ SIP_C2;
      chain_v[3] = hash_key_hi ^ SIP_C3;
      msg_len = '0;
      msg_open = 1'b1;
    end
    nbytes = (!beat.last_word || beat.byte_count > FULL_COUNT) ? FULL_COUNT : beat.byte_count;
    msg_len = msg_len + {4'd0, nbytes};
    if (!beat.last_word) begin
      absorb_block(beat.message_word);
    end else begin
      tail = '0;
      if (nbytes == FULL_COUNT) begin
        absorb_block(beat.message_word);
      end else if (nbytes != 0) begin
        tail = beat.message_word & ((64'd1 << (8 * nbytes)) - 64'd1);
      end
      tail = tail | ({56'd0, msg_len} << LEN_SHIFT);
      absorb_block(tail);
      chain_v[2] = chain_v[2] ^ SIP_FINAL_XOR;
      sip_mix(4);
      dg = chain_v[0] ^ chain_v[1] ^ chain_v[2] ^ chain_v[3];
      res.digest = dg;
      res.digest_folded = dg[63:32] ^ dg[31:0];
      digests_due.push_back(res);
      msg_open = 1'b0;
    end
  endfunction

  function automatic int unsigned gap_draw(bit calm);
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic void queue_beat(logic [63:0] w, logic [3:0] cnt, logic lst);
    in_item_t b;
    b.message_word = w;
    b.byte_count = cnt;
    b.last_word = lst;
    words_pending.push_back(b);
  endfunction

  function automatic void queue_rand_beat(bit lst);
    logic [3:0] cnt;
    if (!lst) begin
      cnt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : FULL_COUNT;
    end else begin
      cnt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    end
    queue_beat({$urandom, $urandom}, cnt, lst);
  endfunction

  function automatic int unsigned queue_rand_message();
    int unsigned n, pick, k;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      n = $urandom_range(1, 4);
    end else if (pick < 95) begin
      n = $urandom_range(5, 12);
    end else begin
      n = $urandom_range(30, 40);
    end
    for (k = 1; k < n; k++) queue_rand_beat(1'b0);
    queue_rand_beat(1'b1);
    return n;
  endfunction

  task automatic write_key(cfg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_KEY_LOW) begin
      hash_key_lo = val;
    end else begin
      hash_key_hi = val;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (words_pending.size() != 0 || in_valid || digests_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_took)) begin
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (words_pending.size() != 0) begin
        in_data <= words_pending.pop_front();
        in_valid <= 1'b1;
        in_gap <= gap_draw(in_calm);
        if ($urandom_range(0, 39) == 0) in_calm <= !in_calm;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_took) begin
      stall_left = gap_draw(out_calm);
      if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
    end
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk) begin
    out_item_t want;
    cycle_cnt <= cycle_cnt + 1;
    in_took <= rst_n && in_valid && !in_stall;
    out_took <= rst_n && out_valid && !out_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (digests_due.size() == 0) begin
          $error("digest: none expected, got %h", out_data.digest);
          fail_cnt++;
        end else begin
          want = digests_due.pop_front();
          if (out_data.digest !== want.digest) begin
            $error("digest: expected %h, got %h", want.digest, out_data.digest);
            fail_cnt++;
          end
          if (out_data.digest_folded !== want.digest_folded) begin
            $error("digest_folded: expected %h, got %h", want.digest_folded,
                   out_data.digest_folded);
            fail_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) hash_word(in_data);
    end
  end

  initial begin
    wait (cycle_cnt == CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned ph, queued;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_KEY_LOW;
    cfg_data = '0;
    hash_key_lo = '0;
    hash_key_hi = '0;
    msg_len = '0;
    msg_open = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    write_key(CFG_KEY_LOW, '0);
    write_key(CFG_KEY_HIGH, '0);
    queue_beat(ONES, 4'd0, 1'b1);
    queue_beat(ONES, 4'd1, 1'b1);
    queue_beat(ONES, 4'd7, 1'b1);
    queue_beat(ONES, 4'd8, 1'b1);
    queue_beat('0, 4'd15, 1'b1);
    queue_beat(64'ha5a5a5a5a5a5a5a5, 4'd9, 1'b1);
    queue_beat('0, 4'd3, 1'b0);
    queue_beat(64'h0123456789abcdef, 4'd4, 1'b1);
    wait_idle();

    write_key(CFG_KEY_LOW, ONES);
    write_key(CFG_KEY_HIGH, ONES);
    queue_beat(ONES, 4'd8, 1'b0);
    queue_beat(ONES, 4'd0, 1'b0);
    queue_beat(ONES, 4'd8, 1'b1);
    queue_beat(64'h5a5a5a5a5a5a5a5a, 4'd8, 1'b0);
    wait_idle();

    write_key(CFG_KEY_LOW, 64'h0706050403020100);
    write_key(CFG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
    queue_beat(64'hfedcba9876543210, 4'd5, 1'b1);
    queue_beat(64'h0706050403020100, 4'd8, 1'b0);
    queue_beat(64'h000e0d0c0b0a0908, 4'd7, 1'b1);
    queue_beat('0, 4'd8, 1'b1);
    wait_idle();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_key(CFG_KEY_LOW, ONES);
          write_key(CFG_KEY_HIGH, ONES);
        end
        1: begin
          write_key(CFG_KEY_LOW, '0);
          write_key(CFG_KEY_HIGH, ONES);
        end
        2: begin
          write_key(CFG_KEY_LOW, ONES);
          write_key(CFG_KEY_HIGH, '0);
        end
        default: begin
          write_key(CFG_KEY_LOW, {$urandom, $urandom});
          write_key(CFG_KEY_HIGH, {$urandom, $urandom});
        end
      endcase
      queued = 0;
      while (queued < PHASE_WORDS) queued += queue_rand_message();
      if (ph % 2 == 0) begin
        queue_rand_beat(1'b0);
        queue_rand_beat(1'b0);
      end
      wait_idle();
    end

    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
